// ===== rtl/slfe_pkg.sv =====
// ----------------------------------------------------------------------------
// slfe_pkg
// Shared constants, types and helpers for the sync/length/checksum frame
// extractor.
// ----------------------------------------------------------------------------
package slfe_pkg;

  localparam int BUFFER_DEPTH  = 256;
  localparam int MAX_FRAME_LEN = 64;

  localparam int PTR_W = $clog2(BUFFER_DEPTH);
  localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
  localparam int CMP_W = (PTR_W >= 8) ? PTR_W + 1 : 9;

  // input and result queue depths
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  // configuration register map
  localparam int       APB_AW      = 3;
  localparam logic     REG_SYNC    = 1'b0;
  localparam logic     REG_MINLEN  = 1'b1;
  localparam logic [7:0] SYNC_RESET   = 8'hAA;
  localparam logic [6:0] MINLEN_RESET = 7'd3;
  localparam int       MIN_LEGAL   = 3;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DROP  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       frame_last;
  } res_t;

  // ring buffer pointer plus offset, wrapping at BUFFER_DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [LEN_W-1:0] off);
    logic [CMP_W-1:0] s;
    s = CMP_W'(ptr) + CMP_W'(off);
    if (s >= CMP_W'(BUFFER_DEPTH)) begin
      s = s - CMP_W'(BUFFER_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/slfe_ram.sv =====
// ----------------------------------------------------------------------------
// slfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/slfe_front.sv =====
// ----------------------------------------------------------------------------
// slfe_front
// Input side: short queue of received bytes ahead of the search engine.
// ----------------------------------------------------------------------------
module slfe_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] byte_i,
  output logic       full_o,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  logic       pop_i
);
  import slfe_pkg::*;

  localparam int IDX_W = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(IQ_DEPTH + 1);

  logic [7:0]       data_q [IQ_DEPTH];
  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(IQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign byte_o  = data_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IDX_W'(IQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == IDX_W'(IQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= byte_i;
    end
  end

endmodule

// ===== rtl/slfe_outq.sv =====
// ----------------------------------------------------------------------------
// slfe_outq
// Result queue between the search engine and the output port.
// ----------------------------------------------------------------------------
module slfe_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  slfe_pkg::res_t       res_i,
  output logic                 full_o,
  output logic                 empty_o,
  output slfe_pkg::res_t       res_o,
  input  logic                 pop_i
);
  import slfe_pkg::*;

  localparam int IDX_W = $clog2(OQ_DEPTH);
  localparam int CNT_W = $clog2(OQ_DEPTH + 1);

  res_t             data_q [OQ_DEPTH];
  logic [IDX_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(OQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = data_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == IDX_W'(OQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == IDX_W'(OQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/slfe_engine.sv =====
// ----------------------------------------------------------------------------
// slfe_engine
// Back end: ring buffer store, frame search, checksum and frame readout.
// ----------------------------------------------------------------------------
module slfe_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           sync_i,
  input  logic [slfe_pkg::LEN_W-1:0] minlen_i,
  input  logic                 in_valid_i,
  input  logic [7:0]           in_byte_i,
  output logic                 in_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output slfe_pkg::res_t       res_o
);
  import slfe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_SYNC = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [LEN_W-1:0] len_q, len_d, idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;

  logic [CMP_W-1:0] count;
  logic [LEN_W-1:0] rd_off;
  logic             ram_we;
  logic [7:0]       rdata;
  logic             idx_end;

  slfe_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_byte_i),
    .raddr_i (ptr_add(rp_q, rd_off)),
    .rdata_o (rdata)
  );

  // bytes held in the ring
  assign count = (wp_q >= rp_q) ? CMP_W'(wp_q) - CMP_W'(rp_q)
                                : CMP_W'(wp_q) + CMP_W'(BUFFER_DEPTH) - CMP_W'(rp_q);
  assign idx_end = (idx_q == len_q - 1'b1);

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    len_d      = len_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    rd_off     = '0;
    ram_we     = 1'b0;
    in_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (count == CMP_W'(BUFFER_DEPTH - 1)) begin
            // ring full: report the byte instead of storing it
            if (!res_full_i) begin
              res_push_o       = 1'b1;
              res_o.kind       = KIND_DROP;
              res_o.frame_byte = in_byte_i;
              res_o.frame_last = 1'b1;
              in_pop_o         = 1'b1;
            end
          end else begin
            ram_we   = 1'b1;
            in_pop_o = 1'b1;
            wp_d     = ptr_add(wp_q, LEN_W'(1));
            state_d  = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (count < CMP_W'(minlen_i)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SYNC;
        end
      end
      S_SYNC: begin
        rd_off = LEN_W'(1);
        if (rdata != sync_i) begin
          rp_d    = ptr_add(rp_q, LEN_W'(1));
          state_d = S_CHK;
        end else begin
          sum_d   = rdata;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        rd_off = LEN_W'(2);
        if (CMP_W'(rdata) < CMP_W'(minlen_i) || CMP_W'(rdata) > CMP_W'(MAX_FRAME_LEN) ||
            CMP_W'(rdata) > CMP_W'(BUFFER_DEPTH - 1)) begin
          rp_d    = ptr_add(rp_q, LEN_W'(1));
          state_d = S_CHK;
        end else if (count < CMP_W'(rdata)) begin
          state_d = S_IDLE;
        end else begin
          len_d   = LEN_W'(rdata);
          sum_d   = sum_q + rdata;
          idx_d   = LEN_W'(2);
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        rd_off = idx_end ? '0 : idx_q + 1'b1;
        if (idx_end) begin
          if (sum_q == rdata) begin
            idx_d   = '0;
            state_d = S_EMIT;
          end else begin
            rp_d    = ptr_add(rp_q, LEN_W'(1));
            state_d = S_CHK;
          end
        end else begin
          sum_d = sum_q + rdata;
          idx_d = idx_q + 1'b1;
        end
      end
      S_EMIT: begin
        // hold the read address while the result queue is full
        rd_off = res_full_i ? idx_q : idx_q + 1'b1;
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.kind       = KIND_FRAME;
          res_o.frame_byte = rdata;
          res_o.frame_last = idx_end;
          if (idx_end) begin
            rp_d    = ptr_add(rp_q, len_q);
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    idx_q <= idx_d;
    sum_q <= sum_d;
  end

endmodule

// ===== rtl/sync_length_sum_frame_extractor.sv =====
// ----------------------------------------------------------------------------
// sync_length_sum_frame_extractor
// Ring-buffered deframer: sync byte, length byte, body, 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Timing: a byte is written to the ring when the engine takes it from the input
//   queue; after a frame's last byte the search runs S_CHK, S_SYNC, S_LEN, S_SUM,
//   then the frame streams at 1 byte/cycle while the result queue has room.
// Service: one byte in service at a time; a bad sync, length or checksum drops one
//   byte and restarts at S_CHK, searching again on the single RAM read port.
// Reset: async active low; ring and queues empty, sync 0xAA, min length 3.
module sync_length_sum_frame_extractor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input (queue-style)
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  byte_in_i,
  // result output (queue-style)
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind_o,
  output logic [7:0]                  frame_byte_o,
  output logic                        frame_last_o,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slfe_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import slfe_pkg::*;

  logic [7:0]       sync_q;
  logic [6:0]       minlen_q;
  logic [LEN_W-1:0] minlen_eff;
  logic             cfg_wr;

  logic             fe_valid, fe_pop;
  logic [7:0]       fe_byte;
  logic             rq_full, rq_push;
  res_t             eng_res, rq_res;

  // --- configuration registers --------------------------------------------
  // zero wait state; register index is the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SYNC_RESET;
      minlen_q <= MINLEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SYNC:   sync_q   <= pwdata[7:0];
        REG_MINLEN: minlen_q <= pwdata[6:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC:   prdata = 32'(sync_q);
      REG_MINLEN: prdata = 32'(minlen_q);
      default:    prdata = '0;
    endcase
  end

  // minimum length clamped into 3..MAX_FRAME_LEN
  always_comb begin
    if (minlen_q < 7'(MIN_LEGAL)) begin
      minlen_eff = LEN_W'(MIN_LEGAL);
    end else if (8'(minlen_q) > 8'(MAX_FRAME_LEN)) begin
      minlen_eff = LEN_W'(MAX_FRAME_LEN);
    end else begin
      minlen_eff = LEN_W'(minlen_q);
    end
  end

  // --- front: input byte queue --------------------------------------------
  slfe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .byte_i  (byte_in_i),
    .full_o  (full),
    .valid_o (fe_valid),
    .byte_o  (fe_byte),
    .pop_i   (fe_pop)
  );

  // --- back: ring buffer, search and readout ------------------------------
  slfe_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sync_i     (sync_q),
    .minlen_i   (minlen_eff),
    .in_valid_i (fe_valid),
    .in_byte_i  (fe_byte),
    .in_pop_o   (fe_pop),
    .res_full_i (rq_full),
    .res_push_o (rq_push),
    .res_o      (eng_res)
  );

  // --- result queue: decouples engine from output stalls ------------------
  slfe_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .res_i   (eng_res),
    .full_o  (rq_full),
    .empty_o (empty),
    .res_o   (rq_res),
    .pop_i   (pop)
  );

  assign kind_o       = rq_res.kind;
  assign frame_byte_o = rq_res.frame_byte;
  assign frame_last_o = rq_res.frame_last;

endmodule

// ===== rtl/slfe_checker.sv =====
// ----------------------------------------------------------------------------
// slfe_checker
// Port-level checks for the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
module slfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       kind_o,
  input logic [7:0] frame_byte_o,
  input logic       frame_last_o,
  input logic       psel,
  input logic       pwrite,
  input logic [2:0] paddr,
  input logic [31:0] prdata
);

  // a waiting result is not withdrawn
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before pop");

  // a waiting result does not change
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(kind_o) && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("result changed while waiting");

  // a drop report always closes its own result group
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o |-> frame_last_o)
    else $error("drop report without last mark");

  // register reads carry no bits beyond the register width
  a_rd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> (paddr[2] ? (prdata[31:7] == '0) : (prdata[31:8] == '0)))
    else $error("register read has stray upper bits");

endmodule

bind sync_length_sum_frame_extractor slfe_checker u_slfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .kind_o       (kind_o),
  .frame_byte_o (frame_byte_o),
  .frame_last_o (frame_last_o),
  .psel         (psel),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .prdata       (prdata)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length/checksum frame extractor. Bytes are
// pushed one request at a time; every accepted byte runs through a cycle-free
// deframing predictor, and each popped result is compared field by field with
// the oldest predicted one. A short directed list comes first, then random
// frames, broken frames and line noise under several register settings and
// handshake idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slfe_pkg::*;

  // Bench knobs
  localparam int BUSY_PCT      = 84;     // idle/stall rate in the heavy phases
  localparam int LIGHT_PCT     = 17;     // idle/stall rate with both sides busy
  localparam int SETTLE_CYCLES = 15000;  // time for bytes still in search to finish
  localparam int HOLD_CYCLES   = 2000;   // long pop hold-off under pressure
  localparam int STALL_LIMIT   = 100000; // cycles with no request accepted
  localparam int PRINT_CAP     = 40;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  // How a directed row is checked: by the predictor, or typed in by hand.
  typedef enum logic [1:0] {ROW_PREDICTED, ROW_NO_OUTPUT, ROW_ENDS_FRAME} row_chk_e;

  typedef struct packed {
    logic [7:0] value;
    row_chk_e   chk;
    logic [6:0] span;   // frame length when the row closes a typed frame
  } dir_row_t;

  typedef struct packed {
    logic [7:0] sync;
    logic [6:0] minlen;
    idle_e      mode;
    logic [8:0] items;
    logic       pressure;
  } phase_t;

  localparam int N_DIRECTED = 23;
  localparam int N_PHASES   = 6;

  // Directed bytes, run with the reset settings (sync 0xAA, min length 3).
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // shortest frame straight after reset
    '{8'hAA, ROW_NO_OUTPUT,  7'd0},
    '{8'h03, ROW_NO_OUTPUT,  7'd0},
    '{8'hAD, ROW_ENDS_FRAME, 7'd3},
    // checksum wraps past 0xFF, body byte at its top value
    '{8'hAA, ROW_NO_OUTPUT,  7'd0},
    '{8'h04, ROW_NO_OUTPUT,  7'd0},
    '{8'hFF, ROW_NO_OUTPUT,  7'd0},
    '{8'hAD, ROW_ENDS_FRAME, 7'd4},
    // frame held incomplete until its last bytes show up
    '{8'hAA, ROW_NO_OUTPUT,  7'd0},
    '{8'h05, ROW_NO_OUTPUT,  7'd0},
    '{8'h01, ROW_NO_OUTPUT,  7'd0},
    '{8'h02, ROW_NO_OUTPUT,  7'd0},
    '{8'hB2, ROW_ENDS_FRAME, 7'd5},
    // wrong sync, length below minimum, length above max, bad checksum,
    // then a good frame found after the resync
    '{8'h00, ROW_PREDICTED,  7'd0},
    '{8'hAA, ROW_PREDICTED,  7'd0},
    '{8'h02, ROW_PREDICTED,  7'd0},
    '{8'hAA, ROW_PREDICTED,  7'd0},
    '{8'h41, ROW_PREDICTED,  7'd0},
    '{8'hAA, ROW_PREDICTED,  7'd0},
    '{8'h03, ROW_PREDICTED,  7'd0},
    '{8'h00, ROW_PREDICTED,  7'd0},
    '{8'hAA, ROW_PREDICTED,  7'd0},
    '{8'h03, ROW_PREDICTED,  7'd0},
    '{8'hAD, ROW_PREDICTED,  7'd0}
  };

  // Random phases. Min length 0 and 2 saturate up to 3, 127 saturates to 64,
  // 64 forces every legal frame to the maximum length.
  localparam phase_t PHASES [N_PHASES] = '{
    '{8'h00, 7'd0,   IDLE_NONE, 9'd60, 1'b0},
    '{8'hFF, 7'd127, IDLE_SEND, 9'd70, 1'b0},
    '{8'h5A, 7'd9,   IDLE_RECV, 9'd55, 1'b0},
    '{8'hAA, 7'd3,   IDLE_BOTH, 9'd60, 1'b0},
    '{8'h3C, 7'd2,   IDLE_NONE, 9'd50, 1'b1},
    '{8'hC3, 7'd64,  IDLE_BOTH, 9'd70, 1'b0}
  };

  // DUT-facing signals, all known from time zero
  logic              clk_i;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic              full;
  logic [7:0]        byte_in = '0;
  logic              empty;
  logic              pop     = 1'b0;
  logic              kind;
  logic [7:0]        frame_byte;
  logic              frame_last;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Predictor state: ring contents, pointers and shadow registers
  logic [7:0]  ring [BUFFER_DEPTH];
  int unsigned rd_ptr     = 0;
  int unsigned wr_ptr     = 0;
  logic [7:0]  cfg_sync   = SYNC_RESET;
  logic [6:0]  cfg_minlen = MINLEN_RESET;

  res_t        frame_bytes_q [$];  // results still owed by the DUT, oldest first
  int unsigned mismatches = 0;
  idle_e       idle_mode  = IDLE_NONE;
  bit          hold_req   = 1'b0;

  sync_length_sum_frame_extractor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .byte_in_i    (byte_in),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind),
    .frame_byte_o (frame_byte),
    .frame_last_o (frame_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Minimum length register is clamped into 3..MAX_FRAME_LEN before use.
  function automatic int unsigned eff_min();
    if (cfg_minlen < MIN_LEGAL) begin
      return MIN_LEGAL;
    end
    if (cfg_minlen > MAX_FRAME_LEN) begin
      return MAX_FRAME_LEN;
    end
    return cfg_minlen;
  endfunction

  // Append one byte, then search from the read side. Bad sync, bad length or
  // bad checksum drops a single byte and retries; at most one frame goes out.
  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned held;
    int unsigned len;
    int unsigned emin;
    logic [7:0]  sum;
    res_t        r;
    emin = eff_min();
    held = (wr_ptr + BUFFER_DEPTH - rd_ptr) % BUFFER_DEPTH;
    if (held >= BUFFER_DEPTH - 1) begin
      // ring full: byte is lost and reported, no search this time
      r.kind       = KIND_DROP;
      r.frame_byte = b;
      r.frame_last = 1'b1;
      frame_bytes_q.push_back(r);
      return;
    end
    ring[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % BUFFER_DEPTH;
    while (1'b1) begin
      held = (wr_ptr + BUFFER_DEPTH - rd_ptr) % BUFFER_DEPTH;
      if (held < emin) begin
        return;
      end
      if (ring[rd_ptr] != cfg_sync) begin
        rd_ptr = (rd_ptr + 1) % BUFFER_DEPTH;
        continue;
      end
      len = ring[(rd_ptr + 1) % BUFFER_DEPTH];
      if (len < emin || len > MAX_FRAME_LEN || len > BUFFER_DEPTH - 1) begin
        rd_ptr = (rd_ptr + 1) % BUFFER_DEPTH;
        continue;
      end
      if (held < len) begin
        return;  // wait for the rest of the frame
      end
      sum = '0;
      for (int unsigned i = 0; i + 1 < len; i++) begin
        sum += ring[(rd_ptr + i) % BUFFER_DEPTH];
      end
      if (sum != ring[(rd_ptr + len - 1) % BUFFER_DEPTH]) begin
        rd_ptr = (rd_ptr + 1) % BUFFER_DEPTH;
        continue;
      end
      for (int unsigned i = 0; i < len; i++) begin
        r.kind       = KIND_FRAME;
        r.frame_byte = ring[(rd_ptr + i) % BUFFER_DEPTH];
        r.frame_last = (i + 1 == len);
        frame_bytes_q.push_back(r);
      end
      rd_ptr = (rd_ptr + len) % BUFFER_DEPTH;
      return;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < BUSY_PCT;
      IDLE_BOTH: return $urandom_range(0, 99) < LIGHT_PCT;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < BUSY_PCT;
      IDLE_BOTH: return $urandom_range(0, 99) < LIGHT_PCT;
      default:   return 1'b0;
    endcase
  endfunction

  // Called at a falling edge with nothing yet driven in that step; returns at
  // a later falling edge, again with nothing driven. Typed rows replace what
  // the predictor produced for that byte (its state still advances).
  task automatic send_byte(input logic [7:0] b, input row_chk_e chk,
                           input int unsigned row);
    int unsigned base;
    res_t        r;
    while (sender_idles()) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    byte_in <= b;
    do @(posedge clk_i); while (full);
    base = frame_bytes_q.size();
    deframe_byte(b);
    if (chk != ROW_PREDICTED) begin
      while (frame_bytes_q.size() > base) begin
        void'(frame_bytes_q.pop_back());
      end
      if (chk == ROW_ENDS_FRAME) begin
        for (int unsigned k = 0; k < DIRECTED[row].span; k++) begin
          r.kind       = KIND_FRAME;
          r.frame_byte = DIRECTED[row - DIRECTED[row].span + 1 + k].value;
          r.frame_last = (k + 1 == DIRECTED[row].span);
          frame_bytes_q.push_back(r);
        end
      end
    end
    @(negedge clk_i);
  endtask

  // Mostly well-formed frames with random bodies; the rest are frames with a
  // corrupted byte or illegal length, truncated frames, and loose noise.
  task automatic send_random(input int unsigned n_items);
    logic [7:0]  seq [$];
    int unsigned sent;
    int unsigned len;
    int unsigned emin;
    int unsigned pick;
    int unsigned k;
    logic [7:0]  sum;
    sent = 0;
    while (sent < n_items) begin
      seq.delete();
      emin = eff_min();
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        repeat ($urandom_range(1, 6)) begin
          seq.push_back(($urandom_range(0, 3) == 0) ? cfg_sync : 8'($urandom));
        end
      end else begin
        // short frames most of the time, the full range now and then
        if ($urandom_range(0, 9) < 8) begin
          len = $urandom_range(emin, (emin + 6 > MAX_FRAME_LEN) ? MAX_FRAME_LEN : emin + 6);
        end else begin
          len = $urandom_range(emin, MAX_FRAME_LEN);
        end
        seq.push_back(cfg_sync);
        seq.push_back(8'(len));
        sum = cfg_sync + 8'(len);
        for (k = 2; k + 1 < len; k++) begin
          seq.push_back(8'($urandom));
          sum += seq[k];
        end
        seq.push_back(sum);
        if (pick >= 80) begin
          seq = seq[0:$urandom_range(0, len - 2)];
        end else if (pick >= 65) begin
          if ($urandom_range(0, 2) == 0) begin
            seq[1] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, emin - 1))
                                                 : 8'($urandom_range(MAX_FRAME_LEN + 1, 255));
          end else begin
            k = $urandom_range(0, len - 1);
            seq[k] = seq[k] ^ 8'($urandom_range(1, 255));
          end
        end
      end
      foreach (seq[i]) begin
        if (sent < n_items) begin
          send_byte(seq[i], ROW_PREDICTED, 0);
          sent++;
        end
      end
    end
  endtask

  // One APB transfer: setup, access, sample, then return to idle.
  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_reg(input logic sel);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b0, {sel, 2'b00}, '0, rd);
    want = (sel == REG_SYNC) ? 32'(cfg_sync) : 32'(cfg_minlen);
    if (rd != want) begin
      report_mismatch((sel == REG_SYNC) ? "sync_byte readback" : "min_frame_len readback",
                      rd, want);
    end
  endtask

  // Upper data bits carry junk; only the register's own width is kept.
  task automatic program_reg(input logic sel, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, {sel, 2'b00}, value, rd);
    if (sel == REG_SYNC) begin
      cfg_sync = value[7:0];
    end else begin
      cfg_minlen = value[6:0];
    end
    check_reg(sel);
  endtask

  // Registers only change with the block idle: every owed result popped,
  // then enough cycles for any byte still being searched to finish.
  task automatic settle();
    push <= 1'b0;
    while (frame_bytes_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop stalls plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned hold_left;
    res_t        want;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      pop <= (hold_left == 0) && !receiver_stalls();
      if (hold_left != 0) begin
        hold_left--;
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("result with nothing owed", 32'({kind, frame_byte, frame_last}),
                          '0);
        end else begin
          want = frame_bytes_q.pop_front();
          if (kind != want.kind) begin
            report_mismatch("kind", 32'(kind), 32'(want.kind));
          end
          if (frame_byte != want.frame_byte) begin
            report_mismatch("frame_byte", 32'(frame_byte), 32'(want.frame_byte));
          end
          if (frame_last != want.frame_last) begin
            report_mismatch("frame_last", 32'(frame_last), 32'(want.frame_last));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any request accepted on either side or APB
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no progress for %0d cycles", $realtime, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers must come out of reset at their documented values
    check_reg(REG_SYNC);
    check_reg(REG_MINLEN);

    idle_mode = IDLE_NONE;
    for (int unsigned r = 0; r < N_DIRECTED; r++) begin
      send_byte(DIRECTED[r].value, DIRECTED[r].chk, r);
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      settle();
      program_reg(REG_SYNC, {24'($urandom), PHASES[p].sync});
      program_reg(REG_MINLEN, {25'($urandom), PHASES[p].minlen});
      idle_mode = PHASES[p].mode;
      // pop side holds off while bytes keep coming: output queue fills and
      // push gets back-pressured through full
      if (PHASES[p].pressure) begin
        hold_req = 1'b1;
      end
      send_random(PHASES[p].items);
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slfe_pkg.sv
rtl/slfe_ram.sv
rtl/slfe_front.sv
rtl/slfe_outq.sv
rtl/slfe_engine.sv
rtl/sync_length_sum_frame_extractor.sv
rtl/slfe_checker.sv
verif/testbench.sv
